### src/bqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pkg
// shared types and constants of the biquad cascade filter
// ----------------------------------------------------------------------------
package bqc_pkg;

    // apb register map, one 64-bit register every 8 bytes
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_B0    = 3'd0;
    localparam logic [2:0] REG_B1    = 3'd1;
    localparam logic [2:0] REG_B2    = 3'd2;
    localparam logic [2:0] REG_A1    = 3'd3;
    localparam logic [2:0] REG_A2    = 3'd4;
    localparam logic [2:0] REG_SHIFT = 3'd5;
    localparam logic [2:0] REG_NSEC  = 3'd6;

    localparam logic [19:0] SHIFT_RESET = 20'd473550;
    localparam logic [2:0]  NSEC_RESET  = 3'd1;

    localparam logic [4:0] SHIFT_MIN = 5'd1;
    localparam logic [4:0] SHIFT_MAX = 5'd30;

    // multiply-accumulate steps of one section
    localparam logic [2:0] STEP_B0 = 3'd0;
    localparam logic [2:0] STEP_B1 = 3'd1;
    localparam logic [2:0] STEP_B2 = 3'd2;
    localparam logic [2:0] STEP_A1 = 3'd3;
    localparam logic [2:0] STEP_A2 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FIN,
        ST_WB
    } t_state;

endpackage

### src/biquad_cascade_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_filter
// cascade of up to four direct-form-I biquads on one shared 16x16 mac
// ----------------------------------------------------------------------------
// usage
//   input request: i_valid / o_ready with i_sample_in, taken while idle
//   output request: o_valid / i_ready with o_sample_out, held in an output
//   register so the next sample can be taken while a result waits
//   config: apb port, 64-bit registers at byte address 8*index, pready tied
//   high; write registers only while no sample is in flight
// timing
//   each section runs five products through the single shared multiplier,
//   one final accumulate, then one shift and history write-back; a sample
//   passes the sections in turn, and no new sample is taken until the
//   last write-back is done and the filter is back in idle
// reset
//   synchronous, active low; coefficients zero, shift 14 in every section,
//   one section, all history reads as zero (per-entry valid bits)
// stall
//   if a result still waits when the next one is done, the last
//   write-back holds until the receiver takes the old result
// ----------------------------------------------------------------------------
module biquad_cascade_filter #(
    parameter int MAX_SECTIONS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample input
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [15:0]          i_sample_in,
    // filtered output
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [15:0]          o_sample_out,
    // apb configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bqc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bqc_pkg::DATA_W-1:0]  pwdata,
    output logic [bqc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [63:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [19:0] r_shift;
    logic [2:0]  r_nsec;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0    <= '0;
            r_b1    <= '0;
            r_b2    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_shift <= bqc_pkg::SHIFT_RESET;
            r_nsec  <= bqc_pkg::NSEC_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bqc_pkg::REG_B0:    r_b0    <= pwdata;
                bqc_pkg::REG_B1:    r_b1    <= pwdata;
                bqc_pkg::REG_B2:    r_b2    <= pwdata;
                bqc_pkg::REG_A1:    r_a1    <= pwdata;
                bqc_pkg::REG_A2:    r_a2    <= pwdata;
                bqc_pkg::REG_SHIFT: r_shift <= pwdata[19:0];
                bqc_pkg::REG_NSEC:  r_nsec  <= pwdata[2:0];
                default: ; // unmapped address, write dropped
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            bqc_pkg::REG_B0:    prdata = r_b0;
            bqc_pkg::REG_B1:    prdata = r_b1;
            bqc_pkg::REG_B2:    prdata = r_b2;
            bqc_pkg::REG_A1:    prdata = r_a1;
            bqc_pkg::REG_A2:    prdata = r_a2;
            bqc_pkg::REG_SHIFT: prdata = {44'd0, r_shift};
            bqc_pkg::REG_NSEC:  prdata = {61'd0, r_nsec};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    bqc_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_sec;     // section being worked on
    logic [2:0]      r_step;    // mac step within the section
    logic            r_out_valid;
    logic signed [15:0] r_out;

    // sections in use, clamped to 1..MAX_SECTIONS
    logic [2:0]    n_eff;
    logic [SW-1:0] last_idx;
    logic          is_last;
    logic          out_free;

    always_comb begin
        n_eff = r_nsec;
        if (r_nsec == 3'd0)
            n_eff = 3'd1;
        else if (r_nsec > 3'(MAX_SECTIONS))
            n_eff = 3'(MAX_SECTIONS);
    end

    assign last_idx = SW'(n_eff - 3'd1);
    assign is_last  = (r_sec == last_idx);
    assign out_free = !r_out_valid || i_ready;

    // ------------------------------------------------------------------
    // history memory: one entry per section, {x1, x2, y1, y2}
    // entries not yet written read as zero through the valid bits
    // ------------------------------------------------------------------
    logic [63:0]   r_hist_mem [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] r_hist_vld;
    logic [63:0]   r_rd_data;
    logic          r_rd_ok;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    logic [63:0]   wr_data;
    logic [63:0]   hist;

    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_hist_mem[r_sec] <= wr_data;
        if (rd_en)
            r_rd_data <= r_hist_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
            r_rd_ok    <= 1'b0;
        end else begin
            if (wr_en)
                r_hist_vld[r_sec] <= 1'b1;
            if (rd_en)
                r_rd_ok <= r_hist_vld[rd_addr];
        end
    end

    assign hist = r_rd_ok ? r_rd_data : 64'd0;

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bqc_pkg::ST_IDLE: if (i_valid) n_state = bqc_pkg::ST_MAC;
            bqc_pkg::ST_MAC:  if (r_step == bqc_pkg::STEP_A2) n_state = bqc_pkg::ST_FIN;
            bqc_pkg::ST_FIN:  n_state = bqc_pkg::ST_WB;
            bqc_pkg::ST_WB: begin
                if (!is_last)
                    n_state = bqc_pkg::ST_MAC;
                else if (out_free)
                    n_state = bqc_pkg::ST_IDLE;
            end
            default: n_state = bqc_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        unique case (r_state)
            bqc_pkg::ST_IDLE: begin
                // keep section 0 history fetched for the next sample
                o_ready = 1'b1;
                rd_en   = 1'b1;
            end
            bqc_pkg::ST_WB: begin
                // write back this section, prefetch the next one
                wr_en   = !is_last || out_free;
                rd_en   = !is_last;
                rd_addr = r_sec + SW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= bqc_pkg::ST_IDLE;
        else
            r_state <= n_state;
    end

    // ------------------------------------------------------------------
    // datapath: shared 16x16 multiplier and 32-bit wrapping accumulator
    // ------------------------------------------------------------------
    logic signed [15:0] r_x;        // input of the current section
    logic signed [31:0] r_prod;
    logic               r_sub;      // feedback terms are subtracted
    logic signed [31:0] r_acc;
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] mul_p;
    logic signed [31:0] acc_sum;
    logic [4:0]         sec_base;
    logic [4:0]         sh;
    logic signed [31:0] acc_sh;
    logic signed [15:0] y;

    // coefficient and history operand for the current step
    always_comb begin
        case (r_step)
            bqc_pkg::STEP_B0: begin
                mul_a = r_b0[r_sec*16 +: 16];
                mul_b = r_x;
            end
            bqc_pkg::STEP_B1: begin
                mul_a = r_b1[r_sec*16 +: 16];
                mul_b = hist[63:48];
            end
            bqc_pkg::STEP_B2: begin
                mul_a = r_b2[r_sec*16 +: 16];
                mul_b = hist[47:32];
            end
            bqc_pkg::STEP_A1: begin
                mul_a = r_a1[r_sec*16 +: 16];
                mul_b = hist[31:16];
            end
            bqc_pkg::STEP_A2: begin
                mul_a = r_a2[r_sec*16 +: 16];
                mul_b = hist[15:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_sum = r_sub ? (r_acc - r_prod) : (r_acc + r_prod);

    // shift: clamp to 1..30, last section +1, others -1
    always_comb begin
        sec_base = r_shift[r_sec*5 +: 5];
        if (sec_base < bqc_pkg::SHIFT_MIN)
            sec_base = bqc_pkg::SHIFT_MIN;
        else if (sec_base > bqc_pkg::SHIFT_MAX)
            sec_base = bqc_pkg::SHIFT_MAX;
        sh = is_last ? (sec_base + 5'd1) : (sec_base - 5'd1);
    end

    assign acc_sh  = r_acc >>> sh;
    assign y       = acc_sh[15:0];
    assign wr_data = {r_x, hist[63:48], y, hist[31:16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec  <= '0;
            r_step <= bqc_pkg::STEP_B0;
        end else begin
            unique case (r_state)
                bqc_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_sec  <= '0;
                        r_step <= bqc_pkg::STEP_B0;
                    end
                end
                bqc_pkg::ST_MAC: r_step <= r_step + 3'd1;
                bqc_pkg::ST_WB: begin
                    if (!is_last) begin
                        r_sec  <= r_sec + SW'(1);
                        r_step <= bqc_pkg::STEP_B0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bqc_pkg::ST_IDLE && i_valid)
            r_x <= i_sample_in;
        else if (wr_en)
            r_x <= y;       // section output feeds the next section
        if (r_state == bqc_pkg::ST_MAC) begin
            r_prod <= mul_p;
            r_sub  <= (r_step == bqc_pkg::STEP_A1) || (r_step == bqc_pkg::STEP_A2);
            r_acc  <= (r_step == bqc_pkg::STEP_B0) ? 32'sd0 : acc_sum;
        end else if (r_state == bqc_pkg::ST_FIN) begin
            r_acc  <= acc_sum;
        end
        if (wr_en && is_last)
            r_out <= y;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (wr_en && is_last)
            r_out_valid <= 1'b1;
        else if (i_ready)
            r_out_valid <= 1'b0;
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

endmodule

### src/bqc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_checker
// port-level checks of the biquad cascade filter
// ----------------------------------------------------------------------------
module bqc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_sample_out
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_out))
        else $error("result changed or dropped while stalled");

    // one sample at a time: busy right after a request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after a request");

    // a result never appears in the cycle after a request
    a_no_instant_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(i_valid && o_ready))
        else $error("result too early after a request");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

bind biquad_cascade_filter bqc_checker u_bqc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_sample_out (o_sample_out)
);
